@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the RTL folder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every rising clk, unless rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Assert that expr never holds at a rising clk, unless rst_n is low.
`define ASSERT_NEVER_CLK(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/ionslot_pkg.sv @@
// Types and constants of the readiness slot.
// Depends on nothing.
`default_nettype none

package ionslot_pkg;

  localparam int unsigned CODE_BITS = 5;
  localparam int unsigned REQ_BITS  = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_REGISTER = 3'd0,
    REQ_SIGNAL   = 3'd1,
    REQ_SHUTDOWN = 3'd2,
    REQ_INIT     = 3'd3,
    REQ_DESTROY  = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_NOT_READY = 2'd0,
    MODE_READY     = 2'd1,
    MODE_WAITING   = 2'd2,
    MODE_SHUTDOWN  = 2'd3
  } slot_mode_e;

  // Single-bit result flags passed from the slot core to the top level.
  typedef struct packed {
    logic dispatch;
    logic took_effect;
    logic fault;
  } flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/ionslot_req_if.sv @@
// Valid/ready channels of the readiness slot: request and response.
// Depends on ionslot_pkg.
`default_nettype none

interface ionslot_req_if
  import ionslot_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [REQ_BITS-1:0]    req_type;
  logic [HANDLE_BITS-1:0] waiter_handle;
  logic [CODE_BITS-1:0]   error_code;

  modport source (output valid, req_type, waiter_handle, error_code, input ready);
  modport sink   (input valid, req_type, waiter_handle, error_code, output ready);
endinterface

interface ionslot_rsp_if
  import ionslot_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic                   dispatch;
  logic [HANDLE_BITS-1:0] dispatch_handle;
  logic [CODE_BITS-1:0]   dispatch_status;
  logic                   took_effect;
  logic                   fault;

  modport source (output valid, dispatch, dispatch_handle, dispatch_status, took_effect,
                  fault, input ready);
  modport sink   (input valid, dispatch, dispatch_handle, dispatch_status, took_effect,
                  fault, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ionslot_core.sv @@
// Slot state registers and the per-request update and result logic.
// Depends on ionslot_pkg.
`default_nettype none

module ionslot_core
  import ionslot_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [REQ_BITS-1:0]    req_type_i,
  input  wire logic [HANDLE_BITS-1:0] handle_i,
  input  wire logic [CODE_BITS-1:0]   code_i,
  output flags_t                      flags_o,
  output logic      [HANDLE_BITS-1:0] disp_handle_o,
  output logic      [CODE_BITS-1:0]   disp_status_o
);

  slot_mode_e             mode_q, mode_d;
  logic [HANDLE_BITS-1:0] pend_q, pend_d;
  logic [CODE_BITS-1:0]   code_q, code_d;

  always_comb begin
    mode_d        = mode_q;
    pend_d        = pend_q;
    code_d        = code_q;
    flags_o       = '0;
    disp_handle_o = '0;
    disp_status_o = '0;
    case (req_type_e'(req_type_i))
      REQ_REGISTER: begin
        case (mode_q)
          MODE_NOT_READY: begin
            mode_d = MODE_WAITING;
            pend_d = handle_i;
          end
          MODE_READY: begin
            mode_d           = MODE_NOT_READY;
            flags_o.dispatch = 1'b1;
            disp_handle_o    = handle_i;
          end
          MODE_SHUTDOWN: begin
            flags_o.dispatch = 1'b1;
            disp_handle_o    = handle_i;
            disp_status_o    = code_q;
          end
          default: flags_o.fault = 1'b1;  // waiter already pending, drop new one
        endcase
      end
      REQ_SIGNAL: begin
        if (mode_q == MODE_NOT_READY) begin
          mode_d = MODE_READY;
        end else if (mode_q == MODE_WAITING) begin
          mode_d           = MODE_NOT_READY;
          flags_o.dispatch = 1'b1;
          disp_handle_o    = pend_q;
        end
      end
      REQ_SHUTDOWN: begin
        if (mode_q != MODE_SHUTDOWN) begin
          if (mode_q == MODE_WAITING) begin
            flags_o.dispatch = 1'b1;
            disp_handle_o    = pend_q;
            disp_status_o    = code_i;
          end
          mode_d              = MODE_SHUTDOWN;
          code_d              = code_i;
          flags_o.took_effect = 1'b1;
        end
      end
      REQ_INIT: begin
        mode_d = MODE_NOT_READY;
        pend_d = '0;
        code_d = '0;
      end
      REQ_DESTROY: begin
        flags_o.fault = (mode_q == MODE_WAITING);
        mode_d        = MODE_SHUTDOWN;
        code_d        = '0;
      end
      default: ;  // unknown request: no change, zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NOT_READY;
      pend_q <= '0;
      code_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      code_q <= code_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/io_readiness_notify_slot.sv @@
// Top level of the readiness slot: request register, slot core, result register.
// Depends on ionslot_pkg, ionslot_req_if, ionslot_rsp_if and ionslot_core.
//
//   channel | dir | modport | payload
//   --------+-----+---------+-------------------------------------------------
//   req_i   | in  | sink    | req_type, waiter_handle, error_code
//   rsp_o   | out | source  | dispatch, dispatch_handle, dispatch_status,
//           |     |         | took_effect, fault
//
// One request per cycle while no result stalls. A request transfer lands in the
// request register; when the result register is free or its result transfers,
// the core updates the slot state and loads the result register, which offers
// the result on rsp_o until it transfers.
// Reset clears the slot to not-ready and empties both registers.
// A stalled result holds in the result register; the request register refills
// in the same cycle its item moves on, so req_i.ready drops only while both hold.
`default_nettype none

module io_readiness_notify_slot
  import ionslot_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  ionslot_req_if.sink  req_i,
  ionslot_rsp_if.source rsp_o
);

  // Request register.
  logic                   in_valid_q;
  logic [REQ_BITS-1:0]    req_type_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [CODE_BITS-1:0]   code_q;

  // Result register.
  logic                   out_valid_q;
  flags_t                 flags_q;
  logic [HANDLE_BITS-1:0] disp_handle_q;
  logic [CODE_BITS-1:0]   disp_status_q;

  // Core results for the item in the request register.
  flags_t                 flags_d;
  logic [HANDLE_BITS-1:0] disp_handle_d;
  logic [CODE_BITS-1:0]   disp_status_d;

  logic advance;
  logic in_xfer;

  // Move the held request into the core when the result register is free or its result transfers.
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_xfer     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_type_q <= req_i.req_type;
      handle_q   <= req_i.waiter_handle;
      code_q     <= req_i.error_code;
    end
  end

  ionslot_core #(
    .HANDLE_BITS(HANDLE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .req_type_i   (req_type_q),
    .handle_i     (handle_q),
    .code_i       (code_q),
    .flags_o      (flags_d),
    .disp_handle_o(disp_handle_d),
    .disp_status_o(disp_status_d)
  );

  // Hold the result until its transfer; load a new one on advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q       <= flags_d;
      disp_handle_q <= disp_handle_d;
      disp_status_q <= disp_status_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.dispatch        = flags_q.dispatch;
  assign rsp_o.dispatch_handle = disp_handle_q;
  assign rsp_o.dispatch_status = disp_status_q;
  assign rsp_o.took_effect     = flags_q.took_effect;
  assign rsp_o.fault           = flags_q.fault;

endmodule

`default_nettype wire

@@ hw/rtl/ionslot_checker.sv @@
// Port-level checks of the readiness slot, bound to the top level.
// Depends on ionslot_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ionslot_checker
  import ionslot_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   rsp_valid_i,
  input wire logic                   rsp_ready_i,
  input wire logic                   dispatch_i,
  input wire logic [HANDLE_BITS-1:0] dispatch_handle_i,
  input wire logic [CODE_BITS-1:0]   dispatch_status_i,
  input wire logic                   took_effect_i,
  input wire logic                   fault_i
);

  // A stalled result stays offered.
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni, (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)

  // No dispatch means zero handle and status.
  `ASSERT_CLK(a_idle_zero, clk_i, rst_ni,
    (rsp_valid_i && !dispatch_i) |-> (dispatch_handle_i == '0 && dispatch_status_i == '0))

  // A faulting request never dispatches.
  `ASSERT_NEVER_CLK(a_fault_disp, clk_i, rst_ni, rsp_valid_i && fault_i && dispatch_i)

  // Shutdown and register/destroy flags never meet.
  `ASSERT_NEVER_CLK(a_took_fault, clk_i, rst_ni, rsp_valid_i && took_effect_i && fault_i)

endmodule

bind io_readiness_notify_slot ionslot_checker #(
  .HANDLE_BITS(HANDLE_BITS)
) u_ionslot_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .dispatch_i       (rsp_o.dispatch),
  .dispatch_handle_i(rsp_o.dispatch_handle),
  .dispatch_status_i(rsp_o.dispatch_status),
  .took_effect_i    (rsp_o.took_effect),
  .fault_i          (rsp_o.fault)
);

`default_nettype wire
